### sv/svae_pkg.sv
// shared types and constants for the sound voice allocator and envelope block
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package svae_pkg;

    // input action and report codes
    localparam logic ACTION_ADD  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_PLAY   = 1'b1;

    // register map (word index)
    localparam logic REG_CEILING = 1'b0;

    localparam logic [14:0] CEIL_RESET = 15'h7FFF;
    localparam logic signed [7:0] PRI_FREE = -8'sd128;
    localparam logic signed [7:0] PRI_ZERO = 8'sd0;
    localparam int DIGITAL_BIT = 7;

    // tone divider: quotient = PITCH_NUM / ((raw >> 3) + PITCH_BIAS)
    localparam int QW       = 13;
    localparam int NW       = 21;
    localparam int DSH_W    = QW + QW - 1;
    localparam int DIV_CW   = 4;
    localparam logic [NW-1:0]     PITCH_NUM  = 21'd1760000;
    localparam logic [QW-1:0]     PITCH_BIAS = 13'd320;
    localparam logic [DIV_CW-1:0] DIV_STEPS  = 4'd13;
    localparam logic signed [16:0] PITCH_MAX = 17'sd32767;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic add_emit;
        logic pick;
        logic update;
        logic div_start;
        logic tick_emit;
    } t_cmd;

    typedef struct packed {
        logic req_tick;
        logic todo_empty;
        logic scan_last;
        logic out_free;
        logic div_busy;
    } t_status;

endpackage

### sv/svae_div.sv
// restoring divider for the tone pitch, one quotient bit per cycle
// depends on svae_pkg
`timescale 1ns / 1ps

module svae_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [svae_pkg::QW-1:0]  i_divisor,
    output logic                     o_busy,
    output logic [svae_pkg::QW-1:0]  o_quotient
);

    logic                          r_busy;
    logic [svae_pkg::DIV_CW-1:0]   r_cnt;
    logic [svae_pkg::NW-1:0]       r_rem;
    logic [svae_pkg::DSH_W-1:0]    r_dsh;
    logic [svae_pkg::QW-1:0]       r_q;

    logic [svae_pkg::DSH_W-1:0]    rem_ext;
    logic [svae_pkg::DSH_W-1:0]    diff;
    logic                          ge;

    assign rem_ext = svae_pkg::DSH_W'(r_rem);
    assign ge      = rem_ext >= r_dsh;
    assign diff    = rem_ext - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= svae_pkg::DIV_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == svae_pkg::DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= svae_pkg::PITCH_NUM;
            r_dsh <= svae_pkg::DSH_W'(i_divisor) << (svae_pkg::QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff[svae_pkg::NW-1:0];
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[svae_pkg::QW-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule

### sv/svae_dp.sv
// voice state, request scan, per-tick envelope update and output register
// depends on svae_pkg and svae_div
`timescale 1ns / 1ps

module svae_dp #(
    parameter int VOICES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  svae_pkg::t_cmd        i_cmd,
    output svae_pkg::t_status     o_status,
    input  logic [14:0]           i_ceiling,
    input  logic                  i_action,
    input  logic [6:0]            i_priority_req,
    input  logic [15:0]           i_owner,
    input  logic [7:0]            i_sound_kind,
    input  logic signed [15:0]    i_start_volume,
    input  logic signed [15:0]    i_volume_step,
    input  logic signed [15:0]    i_start_pitch,
    input  logic signed [15:0]    i_pitch_step,
    input  logic [15:0]           i_duration,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_report_kind,
    output logic [1:0]            o_voice,
    output logic                  o_accepted,
    output logic [14:0]           o_play_volume,
    output logic [12:0]           o_play_pitch,
    output logic [7:0]            o_play_type,
    output logic                  o_last
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int IW = (VW > 2) ? VW : 2;

    // voice state
    logic                r_active   [VOICES];
    logic signed [7:0]   r_pri      [VOICES];
    logic [7:0]          r_type     [VOICES];
    logic [15:0]         r_len      [VOICES];
    logic signed [15:0]  r_vol      [VOICES];
    logic signed [15:0]  r_vstep    [VOICES];
    logic signed [15:0]  r_pitch    [VOICES];
    logic signed [15:0]  r_pstep    [VOICES];
    logic [15:0]         r_owner    [VOICES];

    // latched request
    logic                r_req_tick;
    logic [6:0]          r_req_pri;
    logic [15:0]         r_req_owner;
    logic [7:0]          r_req_kind;
    logic signed [15:0]  r_req_vol;
    logic signed [15:0]  r_req_vstep;
    logic signed [15:0]  r_req_pitch;
    logic signed [15:0]  r_req_pstep;
    logic [15:0]         r_req_dur;

    // scan and tick bookkeeping
    logic [VW-1:0]       r_idx;
    logic [VOICES-1:0]   r_todo;
    logic                r_last;
    logic                r_match_hit;
    logic [VW-1:0]       r_match_idx;
    logic signed [7:0]   r_min_pri;
    logic [VW-1:0]       r_min_idx;

    // output register
    logic                r_out_valid;
    logic                r_out_kind;
    logic [1:0]          r_out_voice;
    logic                r_out_acc;
    logic [14:0]         r_out_vol;
    logic [12:0]         r_out_pitch;
    logic [7:0]          r_out_type;
    logic                r_out_last;

    logic [VOICES-1:0]   todo_init;
    logic [VW-1:0]       first_idx;
    logic [VOICES-1:0]   todo_rest;
    logic                hit_k;
    logic                take;
    logic [VW-1:0]       sel;
    logic [IW-1:0]       sel_ext;
    logic [IW-1:0]       idx_ext;
    logic                out_free;

    logic [15:0]         len_n;
    logic signed [16:0]  vsum;
    logic signed [16:0]  psum;
    logic signed [15:0]  vclip;
    logic signed [15:0]  pclip;
    logic                off;

    logic [svae_pkg::QW-1:0] divisor;
    logic                    div_busy;
    logic [svae_pkg::QW-1:0] quotient;

    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            todo_init[i] = (i < VOICES - 1) && r_active[i] && !r_type[i][svae_pkg::DIGITAL_BIT];
        end
    end

    // lowest pending voice
    always_comb begin
        first_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (r_todo[i]) begin
                first_idx = VW'(i);
            end
        end
    end

    always_comb begin
        todo_rest = r_todo;
        todo_rest[first_idx] = 1'b0;
    end

    assign hit_k = (r_owner[r_idx] == r_req_owner) &&
                   (r_pri[r_idx] == $signed({1'b0, r_req_pri}));
    assign take  = r_match_hit || (r_min_pri == svae_pkg::PRI_ZERO) ||
                   (r_min_pri == svae_pkg::PRI_FREE);
    assign sel     = r_match_hit ? r_match_idx : r_min_idx;
    assign sel_ext = IW'(sel);
    assign idx_ext = IW'(r_idx);

    // envelope step for voice r_idx
    assign len_n = r_len[r_idx] - 16'd1;
    assign vsum  = 17'(r_vol[r_idx]) + 17'(r_vstep[r_idx]);
    assign psum  = 17'(r_pitch[r_idx]) + 17'(r_pstep[r_idx]);
    assign vclip = (vsum > $signed({2'b00, i_ceiling})) ? $signed({1'b0, i_ceiling})
                                                       : vsum[15:0];
    assign pclip = (psum > svae_pkg::PITCH_MAX) ? 16'sh7FFF : psum[15:0];
    assign off   = (len_n == 16'd0) || vsum[16] || psum[16];

    assign divisor = svae_pkg::QW'(r_pitch[r_idx][14:3]) + svae_pkg::PITCH_BIAS;

    svae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_active[i] <= 1'b0;
                r_pri[i]    <= svae_pkg::PRI_FREE;
            end
            r_idx       <= '0;
            r_todo      <= '0;
            r_last      <= 1'b0;
            r_match_hit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx       <= '0;
                r_todo      <= todo_init;
                r_match_hit <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (!r_match_hit && hit_k) begin
                    r_match_hit <= 1'b1;
                end
            end
            if (i_cmd.pick) begin
                r_idx  <= first_idx;
                r_todo <= todo_rest;
                r_last <= (todo_rest == '0);
            end
            if (i_cmd.add_emit && take) begin
                r_active[sel] <= 1'b1;
                r_pri[sel]    <= $signed({1'b0, r_req_pri});
            end
            if (i_cmd.update && off) begin
                r_active[r_idx] <= 1'b0;
                r_pri[r_idx]    <= svae_pkg::PRI_FREE;
            end
            if (i_cmd.add_emit || i_cmd.tick_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_tick  <= (i_action == svae_pkg::ACTION_TICK);
            r_req_pri   <= i_priority_req;
            r_req_owner <= i_owner;
            r_req_kind  <= i_sound_kind;
            r_req_vol   <= i_start_volume;
            r_req_vstep <= i_volume_step;
            r_req_pitch <= i_start_pitch;
            r_req_pstep <= i_pitch_step;
            r_req_dur   <= i_duration;
        end
        if (i_cmd.scan_step) begin
            if (!r_match_hit && hit_k) begin
                r_match_idx <= r_idx;
            end
            if ((r_idx == '0) || (r_min_pri > r_pri[r_idx])) begin
                r_min_pri <= r_pri[r_idx];
                r_min_idx <= r_idx;
            end
        end
        if (i_cmd.add_emit && take) begin
            r_type[sel]  <= r_req_kind;
            r_vol[sel]   <= r_req_vol;
            r_vstep[sel] <= r_req_vstep;
            r_pitch[sel] <= r_req_pitch;
            r_pstep[sel] <= r_req_pstep;
            r_len[sel]   <= r_req_dur;
            r_owner[sel] <= r_req_owner;
        end else if (i_cmd.update) begin
            r_len[r_idx] <= len_n;
            if (off) begin
                r_vol[r_idx]   <= '0;
                r_pitch[r_idx] <= '0;
                r_type[r_idx]  <= '0;
            end else begin
                r_vol[r_idx]   <= vclip;
                r_pitch[r_idx] <= pclip;
            end
        end
        if (i_cmd.add_emit) begin
            r_out_kind  <= svae_pkg::KIND_ADD;
            r_out_voice <= take ? sel_ext[1:0] : 2'd0;
            r_out_acc   <= take;
            r_out_vol   <= '0;
            r_out_pitch <= '0;
            r_out_type  <= '0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.tick_emit) begin
            r_out_kind  <= svae_pkg::KIND_PLAY;
            r_out_voice <= idx_ext[1:0];
            r_out_acc   <= 1'b0;
            r_out_vol   <= r_vol[r_idx][14:0];
            r_out_pitch <= quotient;
            r_out_type  <= r_type[r_idx];
            r_out_last  <= r_last;
        end
    end

    always_comb begin
        o_status.req_tick   = r_req_tick;
        o_status.todo_empty = (r_todo == '0);
        o_status.scan_last  = (r_idx == VW'(VOICES - 1));
        o_status.out_free   = out_free;
        o_status.div_busy   = div_busy;
    end

    assign o_out_valid   = r_out_valid;
    assign o_report_kind = r_out_kind;
    assign o_voice       = r_out_voice;
    assign o_accepted    = r_out_acc;
    assign o_play_volume = r_out_vol;
    assign o_play_pitch  = r_out_pitch;
    assign o_play_type   = r_out_type;
    assign o_last        = r_out_last;

endmodule

### sv/svae_ctrl.sv
// sequencing state machine for add scans and tick updates
// depends on svae_pkg
`timescale 1ns / 1ps

module svae_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  svae_pkg::t_status  i_status,
    output svae_pkg::t_cmd     o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DISPATCH = 9'b000000010,
        ST_SCAN     = 9'b000000100,
        ST_COMMIT   = 9'b000001000,
        ST_PICK     = 9'b000010000,
        ST_UPD      = 9'b000100000,
        ST_DIVGO    = 9'b001000000,
        ST_DIVW     = 9'b010000000,
        ST_EMIT     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!i_status.req_tick) begin
                    n_state = ST_SCAN;
                end else if (i_status.todo_empty) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PICK;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.add_emit = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DIVGO;
            end
            ST_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVW;
            end
            ST_DIVW: begin
                if (!i_status.div_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.tick_emit = 1'b1;
                    n_state = i_status.todo_empty ? ST_IDLE : ST_PICK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### sv/sound_voice_allocator_envelope.sv
// top level of the sound voice allocator with per-tick envelope and pitch slide
// depends on svae_pkg, svae_ctrl, svae_dp (which holds svae_div)
//
// usage:
//   input channel (i_in_valid / o_in_stall) takes one request at a time: an add
//   (action 0) or a frame tick (action 1); o_in_stall is high while a request
//   is being worked on
//   output channel (o_out_valid / i_out_stall) carries the reports through one
//   output register; o_last marks the final report of a request
//   an add scans the voices, one compared per cycle, then decides once the output
//   register is free and raises its one report; the input is free as it appears
//   a tick gives one report per active non-digital voice among the first
//   VOICES-1; each goes through pick, update and the 13-step pitch divider
//   a tick with nothing to update gives no report and frees the input after dispatch
//   a stalled receiver holds the report; the block waits before emitting the next
//   reset frees every voice and sets the volume ceiling to 32767
//   the volume ceiling is written through the apb port at address 0
`timescale 1ns / 1ps

module sound_voice_allocator_envelope #(
    parameter int VOICES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_action,
    input  logic [6:0]          i_priority_req,
    input  logic [15:0]         i_owner,
    input  logic [7:0]          i_sound_kind,
    input  logic signed [15:0]  i_start_volume,
    input  logic signed [15:0]  i_volume_step,
    input  logic signed [15:0]  i_start_pitch,
    input  logic signed [15:0]  i_pitch_step,
    input  logic [15:0]         i_duration,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_report_kind,
    output logic [1:0]          o_voice,
    output logic                o_accepted,
    output logic [14:0]         o_play_volume,
    output logic [12:0]         o_play_pitch,
    output logic [7:0]          o_play_type,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [14:0]        r_ceiling;
    svae_pkg::t_cmd     cmd;
    svae_pkg::t_status  status;
    logic               cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == svae_pkg::REG_CEILING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= svae_pkg::CEIL_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_ceiling <= pwdata[14:0];
        end
    end

    assign prdata = cfg_hit ? {17'd0, r_ceiling} : 32'd0;

    svae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    svae_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_ceiling      (r_ceiling),
        .i_action       (i_action),
        .i_priority_req (i_priority_req),
        .i_owner        (i_owner),
        .i_sound_kind   (i_sound_kind),
        .i_start_volume (i_start_volume),
        .i_volume_step  (i_volume_step),
        .i_start_pitch  (i_start_pitch),
        .i_pitch_step   (i_pitch_step),
        .i_duration     (i_duration),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_report_kind  (o_report_kind),
        .o_voice        (o_voice),
        .o_accepted     (o_accepted),
        .o_play_volume  (o_play_volume),
        .o_play_pitch   (o_play_pitch),
        .o_play_type    (o_play_type),
        .o_last         (o_last)
    );

endmodule

### test/svae_report_checker.sv
// report checker for sound_voice_allocator_envelope: watches the request, report
// and apb channels, keeps its own voice table and compares every report in order
// depends on svae_pkg
`timescale 1ns / 1ps

module svae_report_checker #(
    parameter int VOICES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_action,
    input  logic [6:0]         i_priority_req,
    input  logic [15:0]        i_owner,
    input  logic [7:0]         i_sound_kind,
    input  logic signed [15:0] i_start_volume,
    input  logic signed [15:0] i_volume_step,
    input  logic signed [15:0] i_start_pitch,
    input  logic signed [15:0] i_pitch_step,
    input  logic [15:0]        i_duration,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_report_kind,
    input  logic [1:0]         i_voice,
    input  logic               i_accepted,
    input  logic [14:0]        i_play_volume,
    input  logic [12:0]        i_play_pitch,
    input  logic [7:0]         i_play_type,
    input  logic               i_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 o_fail_count,
    output int                 o_reports_due,
    output int                 o_add_reports,
    output int                 o_rejects,
    output int                 o_play_reports,
    output int                 o_silenced
);

    localparam int TONE_NUM  = 1760000;
    localparam int TONE_BIAS = 320;
    localparam int SLIDE_MAX = 32767;

    typedef struct packed {
        logic        kind;
        logic [1:0]  voice;
        logic        accepted;
        logic [14:0] volume;
        logic [12:0] pitch;
        logic [7:0]  ptype;
        logic        last;
    } t_report;

    t_report due_reports[$];

    logic [14:0]        ceiling;
    logic               on_air[VOICES];
    logic signed [7:0]  prio[VOICES];
    logic [7:0]         vtype[VOICES];
    logic [15:0]        remaining[VOICES];
    logic signed [15:0] level[VOICES];
    logic signed [15:0] level_step[VOICES];
    logic signed [15:0] raw_pitch[VOICES];
    logic signed [15:0] raw_pitch_step[VOICES];
    logic [15:0]        holder[VOICES];

    function automatic logic [12:0] tone_of(logic signed [15:0] raw);
        int d;
        d = (int'(raw) >>> 3) + TONE_BIAS;
        return 13'(TONE_NUM / d);
    endfunction

    task automatic clear_voices();
        ceiling = svae_pkg::CEIL_RESET;
        for (int i = 0; i < VOICES; i++) begin
            on_air[i] = 1'b0;
            prio[i] = svae_pkg::PRI_FREE;
            vtype[i] = '0;
            remaining[i] = '0;
            level[i] = '0;
            level_step[i] = '0;
            raw_pitch[i] = '0;
            raw_pitch_step[i] = '0;
            holder[i] = '0;
        end
    endtask

    task automatic silence_voice(int v);
        level[v] = '0;
        raw_pitch[v] = '0;
        prio[v] = svae_pkg::PRI_FREE;
        vtype[v] = '0;
        on_air[v] = 1'b0;
    endtask

    task automatic allocate_voice();
        int sel;
        int m;
        t_report r;
        sel = -1;
        for (int i = 0; i < VOICES; i++) begin
            if (sel < 0 && holder[i] == i_owner && int'(prio[i]) == int'(i_priority_req))
                sel = i;
        end
        if (sel < 0) begin
            m = 0;
            for (int i = 1; i < VOICES; i++) begin
                if (prio[m] > prio[i])
                    m = i;
            end
            if ((prio[m] == svae_pkg::PRI_ZERO || prio[m] == svae_pkg::PRI_FREE) &&
                int'(prio[m]) <= int'(i_priority_req))
                sel = m;
        end
        r = '0;
        r.kind = svae_pkg::KIND_ADD;
        r.last = 1'b1;
        if (sel >= 0) begin
            prio[sel] = 8'(i_priority_req);
            vtype[sel] = i_sound_kind;
            level[sel] = i_start_volume;
            level_step[sel] = i_volume_step;
            raw_pitch[sel] = i_start_pitch;
            raw_pitch_step[sel] = i_pitch_step;
            remaining[sel] = i_duration;
            holder[sel] = i_owner;
            on_air[sel] = 1'b1;
            r.voice = 2'(sel);
            r.accepted = 1'b1;
        end
        due_reports.push_back(r);
    endtask

    task automatic advance_frame();
        int s;
        logic have;
        t_report held;
        t_report r;
        have = 1'b0;
        held = '0;
        for (int i = 0; i < VOICES - 1; i++) begin
            if (!on_air[i] || vtype[i][svae_pkg::DIGITAL_BIT])
                continue;
            remaining[i] = remaining[i] - 16'd1;
            if (remaining[i] == 16'd0) begin
                silence_voice(i);
            end else begin
                s = int'(level[i]) + int'(level_step[i]);
                if (s < 0) begin
                    silence_voice(i);
                end else begin
                    if (s > int'(ceiling))
                        s = int'(ceiling);
                    level[i] = 16'(s);
                    s = int'(raw_pitch[i]) + int'(raw_pitch_step[i]);
                    if (s < 0) begin
                        silence_voice(i);
                    end else begin
                        if (s > SLIDE_MAX)
                            s = SLIDE_MAX;
                        raw_pitch[i] = 16'(s);
                    end
                end
            end
            r = '0;
            r.kind = svae_pkg::KIND_PLAY;
            r.voice = 2'(i);
            r.volume = level[i][14:0];
            r.pitch = tone_of(raw_pitch[i]);
            r.ptype = vtype[i];
            if (have)
                due_reports.push_back(held);
            held = r;
            have = 1'b1;
        end
        if (have) begin
            held.last = 1'b1;
            due_reports.push_back(held);
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_report();
        t_report want;
        if (due_reports.size() == 0) begin
            $error("report with nothing due: kind %0d voice %0d", i_report_kind, i_voice);
            o_fail_count++;
        end else begin
            want = due_reports.pop_front();
            check_field("report_kind", want.kind, i_report_kind);
            check_field("voice", want.voice, i_voice);
            check_field("accepted", want.accepted, i_accepted);
            check_field("play_volume", want.volume, i_play_volume);
            check_field("play_pitch", want.pitch, i_play_pitch);
            check_field("play_type", want.ptype, i_play_type);
            check_field("last", want.last, i_last);
            if (want.kind == svae_pkg::KIND_ADD) begin
                o_add_reports++;
                if (!want.accepted)
                    o_rejects++;
            end else begin
                o_play_reports++;
                if (want.ptype == 8'd0 && want.volume == 15'd0)
                    o_silenced++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_voices();
            due_reports.delete();
            o_fail_count = 0;
            o_add_reports = 0;
            o_rejects = 0;
            o_play_reports = 0;
            o_silenced = 0;
        end else begin
            if (i_out_valid && !i_out_stall)
                compare_report();
            if (psel && penable && pwrite && pready &&
                (paddr >> 2) == 3'(svae_pkg::REG_CEILING))
                ceiling = pwdata[14:0];
            if (i_in_valid && !i_in_stall) begin
                if (i_action == svae_pkg::ACTION_ADD)
                    allocate_voice();
                else
                    advance_frame();
            end
        end
        o_reports_due = due_reports.size();
    end

endmodule

### test/testbench.sv
// top of the sound_voice_allocator_envelope test: clock, reset, request stimulus,
// receiver stalls, ceiling writes over apb, watchdog and verdict
// depends on svae_pkg, sound_voice_allocator_envelope and svae_report_checker
`timescale 1ns / 1ps

module testbench;

    localparam int VOICES     = 4;
    localparam int HALF       = 5;
    localparam int SETTLE     = 80;
    localparam int IDLE_LIMIT = 1500;
    localparam int PHASES     = 4;
    localparam int PHASE_REQS = 23;

    typedef struct packed {
        logic               action;
        logic [6:0]         pri;
        logic [15:0]        owner;
        logic [7:0]         kind;
        logic signed [15:0] svol;
        logic signed [15:0] vstep;
        logic signed [15:0] spitch;
        logic signed [15:0] pstep;
        logic [15:0]        dur;
    } t_request;

    localparam int REQ_W = $bits(t_request);

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic [6:0]         i_priority_req;
    logic [15:0]        i_owner;
    logic [7:0]         i_sound_kind;
    logic signed [15:0] i_start_volume;
    logic signed [15:0] i_volume_step;
    logic signed [15:0] i_start_pitch;
    logic signed [15:0] i_pitch_step;
    logic [15:0]        i_duration;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_report_kind;
    logic [1:0]         o_voice;
    logic               o_accepted;
    logic [14:0]        o_play_volume;
    logic [12:0]        o_play_pitch;
    logic [7:0]         o_play_type;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_total;
    int reports_due;
    int add_reports;
    int rejects;
    int play_reports;
    int silenced;

    int  idle_cycles;
    int  burst_left;
    int  stall_run;
    int  adds_sent;
    int  ticks_sent;
    int  ceilings_set;
    logic stall_now;
    logic idling;

    sound_voice_allocator_envelope #(.VOICES(VOICES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_action(i_action), .i_priority_req(i_priority_req), .i_owner(i_owner),
        .i_sound_kind(i_sound_kind), .i_start_volume(i_start_volume),
        .i_volume_step(i_volume_step), .i_start_pitch(i_start_pitch),
        .i_pitch_step(i_pitch_step), .i_duration(i_duration),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_report_kind(o_report_kind), .o_voice(o_voice), .o_accepted(o_accepted),
        .o_play_volume(o_play_volume), .o_play_pitch(o_play_pitch),
        .o_play_type(o_play_type), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    svae_report_checker #(.VOICES(VOICES)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_action(i_action), .i_priority_req(i_priority_req), .i_owner(i_owner),
        .i_sound_kind(i_sound_kind), .i_start_volume(i_start_volume),
        .i_volume_step(i_volume_step), .i_start_pitch(i_start_pitch),
        .i_pitch_step(i_pitch_step), .i_duration(i_duration),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_report_kind(o_report_kind), .i_voice(o_voice), .i_accepted(o_accepted),
        .i_play_volume(o_play_volume), .i_play_pitch(o_play_pitch),
        .i_play_type(o_play_type), .i_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_fail_count(fail_total), .o_reports_due(reports_due),
        .o_add_reports(add_reports), .o_rejects(rejects),
        .o_play_reports(play_reports), .o_silenced(silenced)
    );

    always #(HALF) i_clk = ~i_clk;

    // receiver stall pattern: alternating runs of random length while idling is set
    always @(negedge i_clk) begin
        if (!idling) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_now = ~stall_now;
                stall_run = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 20);
            end
            stall_run--;
            i_out_stall <= stall_now;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_req(t_request r);
        int gap;
        if (idling) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 6);
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        i_action = r.action;
        i_priority_req = r.pri;
        i_owner = r.owner;
        i_sound_kind = r.kind;
        i_start_volume = r.svol;
        i_volume_step = r.vstep;
        i_start_pitch = r.spitch;
        i_pitch_step = r.pstep;
        i_duration = r.dur;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (r.action == svae_pkg::ACTION_ADD)
            adds_sent++;
        else
            ticks_sent++;
    endtask

    task automatic add_req(logic [6:0] pri, logic [15:0] owner, logic [7:0] kind,
                           logic signed [15:0] svol, logic signed [15:0] vstep,
                           logic signed [15:0] spitch, logic signed [15:0] pstep,
                           logic [15:0] dur);
        t_request r;
        r = '{svae_pkg::ACTION_ADD, pri, owner, kind, svol, vstep, spitch, pstep, dur};
        send_req(r);
    endtask

    task automatic tick_req();
        t_request r;
        r = '0;
        r.action = svae_pkg::ACTION_TICK;
        send_req(r);
    endtask

    // block is idle once nothing is due and an empty tick has had time to finish
    task automatic drain();
        i_in_valid = 1'b0;
        while (reports_due != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_ceiling(logic [14:0] value);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {svae_pkg::REG_CEILING, 2'b00};
        pwdata = {17'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        ceilings_set++;
    endtask

    // mostly a small owner and priority pool so voices get reused and freed
    function automatic t_request rand_req();
        t_request r;
        r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
        r.action = ($urandom_range(0, 99) < 45) ? svae_pkg::ACTION_TICK : svae_pkg::ACTION_ADD;
        if (r.action == svae_pkg::ACTION_ADD) begin
            if ($urandom_range(0, 4) != 0)
                r.pri = 7'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0)
                r.owner = 16'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: r.kind = 8'h80 | 8'($urandom);
                1: r.kind = 8'($urandom);
                default: r.kind = 8'($urandom_range(1, 3));
            endcase
            if ($urandom_range(0, 4) != 0) begin
                r.svol = 16'($urandom_range(0, 20000));
                r.vstep = $signed(16'($urandom_range(0, 4000))) - 16'sd1000;
                r.spitch = 16'($urandom_range(0, 30000));
                r.pstep = $signed(16'($urandom_range(0, 3500))) - 16'sd500;
            end
            case ($urandom_range(0, 9))
                0: r.dur = 16'd0;
                1: r.dur = 16'hFFFF;
                2: r.dur = 16'($urandom);
                default: r.dur = 16'($urandom_range(1, 6));
            endcase
        end
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = svae_pkg::ACTION_ADD;
        i_priority_req = '0;
        i_owner = '0;
        i_sound_kind = '0;
        i_start_volume = '0;
        i_volume_step = '0;
        i_start_pitch = '0;
        i_pitch_step = '0;
        i_duration = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        burst_left = 0;
        stall_run = 0;
        stall_now = 1'b0;
        adds_sent = 0;
        ticks_sent = 0;
        ceilings_set = 0;
        idling = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset ceiling
        tick_req();
        add_req(7'd0, 16'd0, 8'd1, 16'sd100, 16'sd200, 16'sd8, 16'sd32767, 16'd3);
        add_req(7'd127, 16'hFFFF, 8'h81, 16'sd32767, -16'sd32768, 16'sd32767,
                -16'sd32768, 16'hFFFF);
        add_req(7'd5, 16'd7, 8'd1, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'd0);
        add_req(7'd5, 16'd7, 8'h7F, 16'sd32767, 16'sd32767, 16'sd32000, 16'sd32767, 16'd0);
        tick_req();
        tick_req();
        tick_req();
        add_req(7'd0, 16'd3, 8'd2, 16'sd0, -16'sd1, 16'sd100, 16'sd0, 16'd100);
        tick_req();
        add_req(7'd2, 16'd4, 8'd2, 16'sd10, 16'sd0, 16'sd0, -16'sd1, 16'd100);
        tick_req();
        add_req(7'd1, 16'd5, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd50);
        add_req(7'd1, 16'd6, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd50);
        add_req(7'd1, 16'd7, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd50);
        add_req(7'd0, 16'd8, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd50);
        tick_req();
        add_req(7'd127, 16'hFFFF, 8'h81, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'd1);
        add_req(7'h55, 16'hAAAA, 8'h55, 16'sh5555, -16'sh5556, 16'sh2AAA, 16'sh5555, 16'h5555);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: write_ceiling(15'd0);
                1: write_ceiling(15'($urandom_range(1, 32766)));
                2: write_ceiling(15'h7FFF);
                default: write_ceiling(15'($urandom_range(1, 2000)));
            endcase
            idling = (phase != 1);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (n == PHASE_REQS / 2)
                    drain();
                send_req(rand_req());
            end
        end

        drain();
        $display("run covered %0d requests (%0d adds, %0d ticks) over %0d ceiling settings",
                 adds_sent + ticks_sent, adds_sent, ticks_sent, ceilings_set);
        $display("reports: %0d add (%0d rejected), %0d play updates, %0d note-offs",
                 add_reports, rejects, play_reports, silenced);
        if (fail_total == 0 && reports_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
